// ----- hw/rtl/bcs_pkg.sv -----
// bcs_pkg: shared types and constants for the box containment suppressor
// no dependencies
`timescale 1ns / 1ps

package bcs_pkg;

  // configuration port
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 8;
  localparam int unsigned RATIO_W     = 4;
  localparam int unsigned MAX_KEPT_W  = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COVER_RATIO = 1'b0,
    CFG_MAX_KEPT    = 1'b1
  } cfg_idx_e;

  localparam logic [RATIO_W-1:0]    RATIO_RESET    = 4'd7;
  localparam logic [MAX_KEPT_W-1:0] MAX_KEPT_RESET = 8'd50;

  // kept counter saturates at its all-ones value
  localparam int unsigned KEPT_W = 9;
  localparam logic [KEPT_W-1:0] KEPT_SAT = '1;

  // result transaction layout
  localparam int unsigned OUT_DATA_W = 16;
  localparam int unsigned OUT_PAD_W  = OUT_DATA_W - KEPT_W - 2;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_DRAIN = 4'b0100,
    ST_DONE  = 4'b1000
  } state_e;

endpackage

// ----- hw/rtl/box_containment_suppressor.sv -----
// box_containment_suppressor: per-frame containment suppression of detection boxes
// depends on bcs_pkg
`timescale 1ns / 1ps

//  channel   | direction | tdata (lsb first)                              | tlast
//  s_axis    | in        | box_left, box_top, box_width, box_height, pad  | frame_last
//  m_axis    | out       | keep, kept_count, frame_rejected, pad          | frame_done
//  cfg       | in        | cfg_idx_i selects cover_ratio_tenths / max_kept, no read-back
//
//  one box per transaction; the box store's single read port scans one earlier entry
//  per cycle into a 3-stage compare, and the next box is accepted only back in ST_IDLE
//  reset clears counters, flags and the output valid; the box store and payload registers are not cleared
//  the next box is accepted while a finished result waits on m_axis_tready

module box_containment_suppressor
  import bcs_pkg::*;
#(
  parameter int unsigned MAX_BOXES  = 256,
  parameter int unsigned COORD_BITS = 14
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,

  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // box_left, box_top, box_width, box_height, zero pad
  input  logic [((4*COORD_BITS-2+7)/8)*8-1:0] s_axis_tdata,
  input  logic                       s_axis_tlast,

  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // keep, kept_count, frame_rejected, zero pad
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,
  output logic                       m_axis_tlast,

  input  logic                       cfg_we_i,
  input  logic [CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]      cfg_data_i
);

  localparam int unsigned CW      = COORD_BITS;
  localparam int unsigned LW      = COORD_BITS - 1;
  localparam int unsigned AW      = 2 * LW;
  localparam int unsigned CMP_W   = AW + RATIO_W;
  localparam int unsigned ENTRY_W = 2 * CW + 2 * LW;
  localparam int unsigned IDX_W   = $clog2(MAX_BOXES);
  localparam int unsigned CNT_W   = $clog2(MAX_BOXES + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_BOXES);

  // configuration
  logic [RATIO_W-1:0]    ratio_q;
  logic [MAX_KEPT_W-1:0] max_kept_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ratio_q    <= RATIO_RESET;
      max_kept_q <= MAX_KEPT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_COVER_RATIO: ratio_q    <= cfg_data_i[RATIO_W-1:0];
        CFG_MAX_KEPT:    max_kept_q <= cfg_data_i[MAX_KEPT_W-1:0];
        default: ;
      endcase
    end
  end

  // control state
  state_e           state_q, state_d;
  logic [CNT_W-1:0] stored_cnt_q, stored_cnt_d;
  logic [CNT_W-1:0] scan_cnt_q, scan_cnt_d;
  logic [KEPT_W-1:0] kept_q, kept_d;
  logic             ovf_q, ovf_d;
  logic             v1_q, v2_q, v3_q;
  logic             hit_q;
  logic             m_valid_q, m_valid_d;
  logic             in_xfer, rd_en, wr_en, out_load;

  // current box
  logic [ENTRY_W-1:0]    cur_q;
  logic                  cur_last_q;
  logic signed [CW-1:0]  cur_left, cur_top;
  logic [LW-1:0]         cur_w, cur_h;
  logic [AW-1:0]         cur_area_q;

  assign cur_left = $signed(cur_q[CW-1:0]);
  assign cur_top  = $signed(cur_q[2*CW-1:CW]);
  assign cur_w    = cur_q[2*CW+LW-1:2*CW];
  assign cur_h    = cur_q[ENTRY_W-1:2*CW+LW];

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // box store
  logic [ENTRY_W-1:0] mem [MAX_BOXES];
  logic [ENTRY_W-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[stored_cnt_q[IDX_W-1:0]] <= cur_q;
    end
    if (rd_en) begin
      rd_q <= mem[scan_cnt_q[IDX_W-1:0]];
    end
  end

  // stage 1: overlap lengths and both box areas
  logic signed [CW-1:0] st_left, st_top;
  logic [LW-1:0]        st_w, st_h;
  logic [LW-1:0]        iw, ih, iw_q, ih_q;
  logic [AW-1:0]        st_area_q;

  assign st_left = $signed(rd_q[CW-1:0]);
  assign st_top  = $signed(rd_q[2*CW-1:CW]);
  assign st_w    = rd_q[2*CW+LW-1:2*CW];
  assign st_h    = rd_q[ENTRY_W-1:2*CW+LW];

  function automatic logic [LW-1:0] overlap(input logic signed [CW-1:0] a0,
                                            input logic [LW-1:0] alen,
                                            input logic signed [CW-1:0] b0,
                                            input logic [LW-1:0] blen);
    logic signed [CW:0] ax, bx, ae, be, lo, hi, diff;
    ax   = (CW+1)'(a0);
    bx   = (CW+1)'(b0);
    ae   = ax + $signed({2'b00, alen});
    be   = bx + $signed({2'b00, blen});
    lo   = (ax > bx) ? ax : bx;
    hi   = (ae < be) ? ae : be;
    diff = hi - lo;
    return (hi > lo) ? diff[LW-1:0] : '0;
  endfunction

  assign iw = overlap(st_left, st_w, cur_left, cur_w);
  assign ih = overlap(st_top, st_h, cur_top, cur_h);

  always_ff @(posedge clk_i) begin
    iw_q       <= iw;
    ih_q       <= ih;
    st_area_q  <= AW'(st_w * st_h);
    cur_area_q <= AW'(cur_w * cur_h);
  end

  // stage 2: intersection area and smaller area
  logic [AW-1:0] inter_q, smaller_area_q;
  logic          pos_q;

  always_ff @(posedge clk_i) begin
    inter_q        <= AW'(iw_q * ih_q);
    smaller_area_q <= (st_area_q < cur_area_q) ? st_area_q : cur_area_q;
    pos_q          <= (st_area_q != '0) && (cur_area_q != '0);
  end

  // stage 3: threshold compare
  logic [CMP_W-1:0] lhs, rhs;

  assign lhs = CMP_W'({inter_q, 3'b000}) + CMP_W'({inter_q, 1'b0});
  assign rhs = CMP_W'(ratio_q * smaller_area_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else if (in_xfer) begin
      hit_q <= 1'b0;
    end else if (v3_q && pos_q && (lhs >= rhs)) begin
      hit_q <= 1'b1;
    end
  end

  // end of item
  logic              full, keep, rejected;
  logic [KEPT_W-1:0] kept_new;
  logic              ovf_new;

  assign full     = (stored_cnt_q == CNT_FULL);
  assign keep     = !hit_q;
  assign kept_new = (keep && kept_q != KEPT_SAT) ? kept_q + 1'b1 : kept_q;
  assign ovf_new  = ovf_q || full;
  assign rejected = cur_last_q && (kept_new > KEPT_W'(max_kept_q) || ovf_new);
  assign out_load = (state_q == ST_DONE) && (!m_valid_q || m_axis_tready);
  assign wr_en    = out_load && !full;

  always_comb begin
    state_d      = state_q;
    stored_cnt_d = stored_cnt_q;
    scan_cnt_d   = scan_cnt_q;
    kept_d       = kept_q;
    ovf_d        = ovf_q;
    rd_en        = 1'b0;
    m_valid_d    = m_valid_q && !m_axis_tready;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          scan_cnt_d = '0;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_cnt_q == stored_cnt_q) begin
          state_d = ST_DRAIN;
        end else begin
          rd_en      = 1'b1;
          scan_cnt_d = scan_cnt_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (!v1_q && !v2_q && !v3_q) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          m_valid_d = 1'b1;
          state_d   = ST_IDLE;
          if (cur_last_q) begin
            stored_cnt_d = '0;
            kept_d       = '0;
            ovf_d        = 1'b0;
          end else begin
            stored_cnt_d = full ? stored_cnt_q : stored_cnt_q + 1'b1;
            kept_d       = kept_new;
            ovf_d        = ovf_new;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      stored_cnt_q <= '0;
      scan_cnt_q   <= '0;
      kept_q       <= '0;
      ovf_q        <= 1'b0;
      v1_q         <= 1'b0;
      v2_q         <= 1'b0;
      v3_q         <= 1'b0;
      m_valid_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      stored_cnt_q <= stored_cnt_d;
      scan_cnt_q   <= scan_cnt_d;
      kept_q       <= kept_d;
      ovf_q        <= ovf_d;
      v1_q         <= rd_en;
      v2_q         <= v1_q;
      v3_q         <= v2_q;
      m_valid_q    <= m_valid_d;
    end
  end

  // payload registers
  logic [OUT_DATA_W-1:0] out_data_q;
  logic                  out_last_q;

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cur_q      <= s_axis_tdata[ENTRY_W-1:0];
      cur_last_q <= s_axis_tlast;
    end
    if (out_load) begin
      out_data_q <= {OUT_PAD_W'(0), rejected, kept_new, keep};
      out_last_q <= cur_last_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  // checks
  a_result_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q == ST_DONE))
    else $error("result raised outside end of item");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stored_cnt_q <= CNT_FULL)
    else $error("stored count beyond store depth");

  a_read_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_en |-> (scan_cnt_q < stored_cnt_q) && !wr_en)
    else $error("store read outside written entries");

  a_reject_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && !cur_last_q |-> !rejected)
    else $error("rejection flagged before last box");

endmodule

// ----- bench/tb.sv -----
// tb: self-checking bench for box_containment_suppressor, boxes in on s_axis, verdicts out on m_axis
// a scoreboard class predicts keep flag, kept count and frame rejection per box; depends on bcs_pkg
`timescale 1ns / 1ps

module tb
  import bcs_pkg::*;
;

  localparam int IN_DATA_W      = 56;
  localparam int STORE_DEPTH    = 256;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int LOG_LIMIT      = 40;

  typedef struct {
    logic signed [13:0] left;
    logic signed [13:0] top;
    logic [12:0]        width;
    logic [12:0]        height;
  } box_t;

  typedef struct {
    logic              keep;
    logic [KEPT_W-1:0] kept_count;
    logic              frame_done;
    logic              frame_rejected;
  } verdict_t;

  class suppression_scoreboard;
    box_t                frame_boxes[$];
    logic [KEPT_W-1:0]   kept_total;
    bit                  overflowed;
    logic [RATIO_W-1:0]  cover_ratio;
    logic [MAX_KEPT_W-1:0] max_kept;
    verdict_t            expected_verdicts[$];
    int mismatch_count, verdicts_seen, frames_closed, frames_rejected, boxes_dropped;

    function new();
      cover_ratio     = RATIO_RESET;
      max_kept        = MAX_KEPT_RESET;
      kept_total      = '0;
      overflowed      = 1'b0;
      mismatch_count  = 0;
      verdicts_seen   = 0;
      frames_closed   = 0;
      frames_rejected = 0;
      boxes_dropped   = 0;
    endfunction

    // half-open overlap of two spans, zero when empty
    function longint span_overlap(longint a0, longint alen, longint b0, longint blen);
      longint lo, hi;
      lo = (a0 > b0) ? a0 : b0;
      hi = ((a0 + alen) < (b0 + blen)) ? (a0 + alen) : (b0 + blen);
      return (hi > lo) ? hi - lo : 0;
    endfunction

    function bit box_is_covered(box_t a, box_t b);
      longint area_a, area_b, smaller_area, ix, iy;
      area_a       = longint'(a.width) * longint'(a.height);
      area_b       = longint'(b.width) * longint'(b.height);
      smaller_area = (area_a < area_b) ? area_a : area_b;
      if (area_a <= 0 || area_b <= 0) return 1'b0;
      ix = span_overlap(longint'(a.left), longint'(a.width), longint'(b.left), longint'(b.width));
      iy = span_overlap(longint'(a.top), longint'(a.height), longint'(b.top), longint'(b.height));
      return (ix * iy * 10) >= (longint'(cover_ratio) * smaller_area);
    endfunction

    function void note_box(box_t b, bit last);
      verdict_t v;
      bit redundant;
      redundant = 1'b0;
      foreach (frame_boxes[i]) begin
        if (box_is_covered(frame_boxes[i], b)) begin
          redundant = 1'b1;
          break;
        end
      end
      if (frame_boxes.size() < STORE_DEPTH) frame_boxes = {frame_boxes, b};
      else overflowed = 1'b1;
      if (!redundant && kept_total != KEPT_SAT) kept_total++;
      v.keep           = !redundant;
      v.kept_count     = kept_total;
      v.frame_done     = last;
      v.frame_rejected = 1'b0;
      if (last) begin
        v.frame_rejected = (kept_total > max_kept) || overflowed;
        frame_boxes.delete();
        kept_total = '0;
        overflowed = 1'b0;
      end
      expected_verdicts = {expected_verdicts, v};
    endfunction

    task report_mismatch(string what);
      mismatch_count++;
      if (mismatch_count <= LOG_LIMIT) $display("[%0t] mismatch: %s", $time, what);
    endtask

    task check_verdict(logic [OUT_DATA_W-1:0] data, logic last);
      verdict_t v;
      verdicts_seen++;
      if (expected_verdicts.size() == 0) begin
        report_mismatch("verdict transaction with no box pending");
        return;
      end
      v = expected_verdicts.pop_front();
      if (data[0] !== v.keep)
        report_mismatch($sformatf("verdict %0d keep %b, want %b", verdicts_seen, data[0], v.keep));
      if (data[KEPT_W:1] !== v.kept_count)
        report_mismatch($sformatf("verdict %0d kept_count %0d, want %0d",
                                  verdicts_seen, data[KEPT_W:1], v.kept_count));
      if (data[KEPT_W+1] !== v.frame_rejected)
        report_mismatch($sformatf("verdict %0d frame_rejected %b, want %b",
                                  verdicts_seen, data[KEPT_W+1], v.frame_rejected));
      if (last !== v.frame_done)
        report_mismatch($sformatf("verdict %0d frame_done %b, want %b",
                                  verdicts_seen, last, v.frame_done));
      if (v.frame_done) frames_closed++;
      if (v.frame_rejected) frames_rejected++;
      if (!v.keep) boxes_dropped++;
    endtask
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_DATA_W-1:0]   s_axis_tdata;
  logic                   s_axis_tlast;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_DATA_W-1:0]  m_axis_tdata;
  logic                   m_axis_tlast;
  logic                   cfg_we_i;
  logic [CFG_IDX_W-1:0]   cfg_idx_i;
  logic [CFG_DATA_W-1:0]  cfg_data_i;

  suppression_scoreboard sb;
  box_t                  frame_sent[$];
  box_t                  seen_box;
  logic                  hold_active;
  int                    sender_idle_pct;
  int                    recv_stall_pct;
  int                    stall_cycles;
  int                    ratio_plan[7] = '{7, 0, 15, 10, 1, 5, 7};
  int                    kept_plan[7]  = '{50, 0, 255, 1, 3, 12, 50};

  box_containment_suppressor i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= !hold_active && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        seen_box.left   = s_axis_tdata[13:0];
        seen_box.top    = s_axis_tdata[27:14];
        seen_box.width  = s_axis_tdata[40:28];
        seen_box.height = s_axis_tdata[53:41];
        sb.note_box(seen_box, s_axis_tlast);
      end
      if (m_axis_tvalid && m_axis_tready) sb.check_verdict(m_axis_tdata, m_axis_tlast);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || cfg_we_i) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles, %0d verdicts pending",
               stall_cycles, sb.expected_verdicts.size());
      $display("FAILURE");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic box_t box_at(int l, int t, int w, int h);
    box_t b;
    b.left   = l[13:0];
    b.top    = t[13:0];
    b.width  = w[12:0];
    b.height = h[12:0];
    return b;
  endfunction

  // mostly boxes nested in or overlapping earlier boxes of the frame
  function automatic box_t make_box();
    box_t p;
    int kind, l, t, w, h;
    kind = $urandom_range(99);
    if (frame_sent.size() != 0) p = frame_sent[$urandom_range(frame_sent.size() - 1)];
    if (kind < 30 && frame_sent.size() != 0) begin
      w = $urandom_range(p.width);
      h = $urandom_range(p.height);
      l = int'(p.left) + int'($urandom_range(int'(p.width) - w));
      t = int'(p.top) + int'($urandom_range(int'(p.height) - h));
    end else if (kind < 55 && frame_sent.size() != 0) begin
      w = int'(p.width) + int'($urandom_range(40)) - 20;
      h = int'(p.height) + int'($urandom_range(40)) - 20;
      if (w < 0) w = 0;
      if (h < 0) h = 0;
      l = int'(p.left) + int'($urandom_range(p.width)) - int'(p.width / 2);
      t = int'(p.top) + int'($urandom_range(p.height)) - int'(p.height / 2);
    end else if (kind < 85) begin
      l = int'($urandom_range(511)) - 256;
      t = int'($urandom_range(511)) - 256;
      w = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 200);
      h = ($urandom_range(19) == 0) ? 0 : $urandom_range(1, 200);
    end else if (kind < 95) begin
      l = $urandom;
      t = $urandom;
      w = $urandom;
      h = $urandom;
    end else begin
      case ($urandom_range(3))
        0: l = -8192;
        1: l = 8191;
        2: l = 0;
        default: l = -1;
      endcase
      case ($urandom_range(3))
        0: t = -8192;
        1: t = 8191;
        2: t = 0;
        default: t = -1;
      endcase
      w = ($urandom_range(1) == 0) ? 8191 : $urandom_range(1);
      h = ($urandom_range(1) == 0) ? 8191 : $urandom_range(1);
    end
    return box_at(l, t, w, h);
  endfunction

  task automatic send_box(box_t b, bit last);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, b.height, b.width, b.top, b.left};
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    if (last) frame_sent.delete();
    else frame_sent = {frame_sent, b};
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic send_frame(int boxes);
    for (int i = 0; i < boxes; i++) send_box(make_box(), i == boxes - 1);
  endtask

  task automatic drain_verdicts();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (sb.expected_verdicts.size() != 0);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] value);
    drain_verdicts();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_COVER_RATIO) sb.cover_ratio = value[RATIO_W-1:0];
    else sb.max_kept = value;
  endtask

  task automatic hold_receiver(int cycles);
    hold_active <= 1'b1;
    repeat (cycles) @(posedge clk_i);
    hold_active <= 1'b0;
  endtask

  function automatic void set_idling(int mode);
    sender_idle_pct = (mode == 1) ? 69 : (mode == 3) ? 12 : 0;
    recv_stall_pct  = (mode == 2) ? 69 : (mode == 3) ? 12 : 0;
  endfunction

  initial begin
    int sent_in_phase, boxes;
    sb            = new();
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    m_axis_tready = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_COVER_RATIO;
    cfg_data_i    = '0;
    hold_active   = 1'b0;
    stall_cycles  = 0;
    set_idling(0);
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: nesting, disjoint, zero width, abutting edges, full-size boxes
    send_box(box_at(0, 0, 100, 100), 1'b0);
    send_box(box_at(10, 10, 50, 50), 1'b0);
    send_box(box_at(500, 500, 10, 10), 1'b0);
    send_box(box_at(10, 10, 0, 50), 1'b0);
    send_box(box_at(100, 0, 100, 100), 1'b0);
    send_box(box_at(-4000, -4000, 8191, 8191), 1'b1);
    send_box(box_at(8191, 8191, 8191, 8191), 1'b1);
    send_box(box_at(-8192, -8192, 8191, 8191), 1'b0);
    send_box(box_at(-8192, -8192, 8191, 8191), 1'b1);

    // ratio zero drops even disjoint boxes, limit zero rejects any kept box
    write_reg(CFG_COVER_RATIO, 8'd0);
    write_reg(CFG_MAX_KEPT, 8'd0);
    send_box(box_at(0, 0, 10, 10), 1'b0);
    send_box(box_at(1000, 1000, 5, 5), 1'b0);
    send_box(box_at(0, 0, 10, 0), 1'b1);

    // ratio above ten never drops
    write_reg(CFG_COVER_RATIO, 8'd15);
    send_box(box_at(0, 0, 20, 20), 1'b0);
    send_box(box_at(0, 0, 20, 20), 1'b1);

    // ratio ten: only full cover of the smaller box drops
    write_reg(CFG_COVER_RATIO, 8'd10);
    write_reg(CFG_MAX_KEPT, 8'd1);
    send_box(box_at(0, 0, 20, 20), 1'b0);
    send_box(box_at(0, 0, 20, 20), 1'b0);
    send_box(box_at(10, 0, 20, 20), 1'b1);

    for (int ph = 0; ph < 7; ph++) begin
      if (ph == 5) begin
        ratio_plan[ph] = $urandom_range(2, 9);
        kept_plan[ph]  = $urandom_range(4, 20);
      end
      write_reg(CFG_COVER_RATIO, CFG_DATA_W'(ratio_plan[ph]));
      write_reg(CFG_MAX_KEPT, CFG_DATA_W'(kept_plan[ph]));
      set_idling(ph % 4);
      if (ph == 4) begin
        fork
          hold_receiver(400);
        join_none
      end
      sent_in_phase = 0;
      while (sent_in_phase < 130) begin
        boxes = ($urandom_range(6) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
        send_frame(boxes);
        sent_in_phase += boxes;
      end
    end

    // long frames: kept count saturation, then store overflow with live compares
    set_idling(0);
    write_reg(CFG_COVER_RATIO, 8'd15);
    write_reg(CFG_MAX_KEPT, 8'd255);
    send_frame(520);
    write_reg(CFG_COVER_RATIO, 8'd7);
    send_frame(260);

    drain_verdicts();
    repeat (300) @(posedge clk_i);
    $display("checked %0d verdicts over %0d frames: %0d boxes suppressed, %0d frames rejected",
             sb.verdicts_seen, sb.frames_closed, sb.boxes_dropped, sb.frames_rejected);
    $display("ratios 0 to 15, kept limits 0 to 255, store overflow and kept count saturation");
    if (sb.mismatch_count == 0 && sb.expected_verdicts.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/bcs_pkg.sv
hw/rtl/box_containment_suppressor.sv
bench/tb.sv
